// ===== hdl/asd_pkg.sv =====
// ---------------------------------------------------------------------------
// asd_pkg
// Shared types and codes of the address stillness detector.
// ---------------------------------------------------------------------------
package asd_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PITCH_HIGH = 3'd0,
      CSR_PITCH_LOW  = 3'd1,
      CSR_ROLL_HIGH  = 3'd2,
      CSR_ROLL_LOW   = 3'd3,
      CSR_MOTION_LIM = 3'd4,
      CSR_HOLD_TIME  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_OUTSIDE    = 2'd0,
      VERDICT_MOVED      = 2'd1,
      VERDICT_SETTLING   = 2'd2,
      VERDICT_AT_ADDRESS = 2'd3
   } verdict_type;

   typedef struct packed {
      logic signed [15:0] pitch_high;
      logic signed [15:0] pitch_low;
      logic signed [15:0] roll_high;
      logic signed [15:0] roll_low;
      logic [15:0]        motion_limit;
      logic [15:0]        hold_time_ms;
   } cfg_type;

   localparam logic signed [15:0] RST_PITCH_HIGH = 16'sd23040;
   localparam logic signed [15:0] RST_PITCH_LOW  = -16'sd23040;
   localparam logic signed [15:0] RST_ROLL_HIGH  = 16'sd23040;
   localparam logic signed [15:0] RST_ROLL_LOW   = -16'sd23040;
   localparam logic [15:0]        RST_MOTION_LIM = 16'd640;
   localparam logic [15:0]        RST_HOLD_TIME  = 16'd1000;

endpackage

// ===== hdl/asd_if.sv =====
// ---------------------------------------------------------------------------
// asd_req_if / asd_rsp_if
// Valid/ready channels for orientation samples and stillness results.
// ---------------------------------------------------------------------------
interface asd_req_if #(
   parameter int ANGLE_WIDTH = 16,
   parameter int STAMP_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] pitch_angle;
   logic signed [ANGLE_WIDTH-1:0] roll_angle;
   logic signed [ANGLE_WIDTH-1:0] yaw_angle;
   logic [STAMP_WIDTH-1:0]        stamp_ms;

   modport source (output valid, pitch_angle, roll_angle, yaw_angle, stamp_ms,
                   input ready);
   modport sink   (input valid, pitch_angle, roll_angle, yaw_angle, stamp_ms,
                   output ready);
endinterface

interface asd_rsp_if;
   logic       valid;
   logic       ready;
   logic       at_address;
   logic [1:0] verdict;

   modport source (output valid, at_address, verdict, input ready);
   modport sink   (input valid, at_address, verdict, output ready);
endinterface

// ===== hdl/asd_judge.sv =====
// ---------------------------------------------------------------------------
// asd_judge
// Window, drift and hold-time checks of one sample against the reference.
// ---------------------------------------------------------------------------
module asd_judge #(
   parameter int ANGLE_WIDTH = 16,
   parameter int STAMP_WIDTH = 32
) (
   input  logic signed [ANGLE_WIDTH-1:0] pitch_angle,
   input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
   input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
   input  logic [STAMP_WIDTH-1:0]        stamp_ms,
   input  logic signed [ANGLE_WIDTH-1:0] ref_pitch,
   input  logic signed [ANGLE_WIDTH-1:0] ref_roll,
   input  logic signed [ANGLE_WIDTH-1:0] ref_yaw,
   input  logic [STAMP_WIDTH-1:0]        still_since_ms,
   input  logic                          ref_loaded,
   input  asd_pkg::cfg_type              cfg,
   output asd_pkg::verdict_type          verdict
);
   import asd_pkg::*;

   localparam int CW = (ANGLE_WIDTH > 16) ? ANGLE_WIDTH : 16;
   localparam int DW = ANGLE_WIDTH + 1;
   localparam int MW = (DW > 16) ? DW : 16;

   // exact |cur - ref_v| > lim, difference kept one bit wider
   function automatic logic drift_exceeds(input logic signed [ANGLE_WIDTH-1:0] cur,
                                          input logic signed [ANGLE_WIDTH-1:0] ref_v,
                                          input logic [15:0] lim);
      logic signed [DW-1:0] diff;
      logic [DW-1:0]        mag;
      diff = DW'(cur) - DW'(ref_v);
      mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
      return MW'(mag) > MW'(lim);
   endfunction

   logic signed [CW-1:0]   pitch_x;
   logic signed [CW-1:0]   roll_x;
   logic                   outside;
   logic                   moved;
   logic [STAMP_WIDTH-1:0] elapsed;

   always_comb begin
      pitch_x = CW'(pitch_angle);
      roll_x  = CW'(roll_angle);
      outside = (pitch_x > CW'($signed(cfg.pitch_high))) ||
                (pitch_x < CW'($signed(cfg.pitch_low)))  ||
                (roll_x  > CW'($signed(cfg.roll_high)))  ||
                (roll_x  < CW'($signed(cfg.roll_low)));
      moved   = !ref_loaded ||
                drift_exceeds(pitch_angle, ref_pitch, cfg.motion_limit) ||
                drift_exceeds(roll_angle, ref_roll, cfg.motion_limit) ||
                drift_exceeds(yaw_angle, ref_yaw, cfg.motion_limit);
      // wraps modulo the stamp width
      elapsed = stamp_ms - still_since_ms;
      priority if (outside) begin
         verdict = VERDICT_OUTSIDE;
      end else if (moved) begin
         verdict = VERDICT_MOVED;
      end else if (elapsed >= STAMP_WIDTH'(cfg.hold_time_ms)) begin
         verdict = VERDICT_AT_ADDRESS;
      end else begin
         verdict = VERDICT_SETTLING;
      end
   end

endmodule

// ===== hdl/address_stillness_detector_core.sv =====
// ---------------------------------------------------------------------------
// address_stillness_detector_core
// Decides per orientation sample whether the club is held still at address.
//
// req_ch carries one sample per word: pitch, roll, yaw and a millisecond
// stamp. rsp_ch returns exactly one word per sample: at_address and a
// two-bit verdict (outside window, moved, settling, at address).
// A sample is captured in an input register; the checks and the reference
// update happen between that register and the result register, which
// drives rsp_ch. Throughput is one sample per cycle while the receiver
// takes results; the reference state loops back through the single check
// stage, so each sample sees its predecessor's update. A stalled receiver
// holds the result register; the input register still takes one more
// sample, then req_ch.ready drops until rsp_ch moves.
// csr_we writes csr_wdata to register csr_index (indexes above 5 ignored);
// write only while the block is idle.
// Reset restores the register defaults, empties both stages and forgets the
// reference, so the first sample after reset loads it.
// ---------------------------------------------------------------------------
module address_stillness_detector_core #(
   parameter int ANGLE_WIDTH = 16,
   parameter int STAMP_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   asd_req_if.sink                              req_ch,
   asd_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [asd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [asd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import asd_pkg::*;

   cfg_type cfg_ff;

   logic                          in_valid_ff;
   logic signed [ANGLE_WIDTH-1:0] in_pitch_ff;
   logic signed [ANGLE_WIDTH-1:0] in_roll_ff;
   logic signed [ANGLE_WIDTH-1:0] in_yaw_ff;
   logic [STAMP_WIDTH-1:0]        in_stamp_ff;

   logic signed [ANGLE_WIDTH-1:0] ref_pitch_ff;
   logic signed [ANGLE_WIDTH-1:0] ref_roll_ff;
   logic signed [ANGLE_WIDTH-1:0] ref_yaw_ff;
   logic [STAMP_WIDTH-1:0]        still_since_ff;
   logic                          ref_loaded_ff;

   logic                          out_valid_ff;
   verdict_type                   out_verdict_ff;

   verdict_type                   verdict;
   logic                          out_load;
   logic                          in_take;
   logic                          reload;

   assign out_load = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign in_take  = req_ch.valid && req_ch.ready;
   assign reload   = (verdict == VERDICT_OUTSIDE) || (verdict == VERDICT_MOVED);

   assign req_ch.ready      = !in_valid_ff || out_load;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.verdict    = out_verdict_ff;
   assign rsp_ch.at_address = (out_verdict_ff == VERDICT_AT_ADDRESS);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pitch_high   <= RST_PITCH_HIGH;
         cfg_ff.pitch_low    <= RST_PITCH_LOW;
         cfg_ff.roll_high    <= RST_ROLL_HIGH;
         cfg_ff.roll_low     <= RST_ROLL_LOW;
         cfg_ff.motion_limit <= RST_MOTION_LIM;
         cfg_ff.hold_time_ms <= RST_HOLD_TIME;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PITCH_HIGH: cfg_ff.pitch_high   <= csr_wdata;
            CSR_PITCH_LOW:  cfg_ff.pitch_low    <= csr_wdata;
            CSR_ROLL_HIGH:  cfg_ff.roll_high    <= csr_wdata;
            CSR_ROLL_LOW:   cfg_ff.roll_low     <= csr_wdata;
            CSR_MOTION_LIM: cfg_ff.motion_limit <= csr_wdata;
            CSR_HOLD_TIME:  cfg_ff.hold_time_ms <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_take) begin
         in_valid_ff <= 1'b1;
      end else if (out_load) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_pitch_ff <= req_ch.pitch_angle;
         in_roll_ff  <= req_ch.roll_angle;
         in_yaw_ff   <= req_ch.yaw_angle;
         in_stamp_ff <= req_ch.stamp_ms;
      end
   end

   asd_judge #(
      .ANGLE_WIDTH (ANGLE_WIDTH),
      .STAMP_WIDTH (STAMP_WIDTH)
   ) u_judge (
      .pitch_angle    (in_pitch_ff),
      .roll_angle     (in_roll_ff),
      .yaw_angle      (in_yaw_ff),
      .stamp_ms       (in_stamp_ff),
      .ref_pitch      (ref_pitch_ff),
      .ref_roll       (ref_roll_ff),
      .ref_yaw        (ref_yaw_ff),
      .still_since_ms (still_since_ff),
      .ref_loaded     (ref_loaded_ff),
      .cfg            (cfg_ff),
      .verdict        (verdict)
   );

   // reference reloads on outside-window and moved verdicts
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_loaded_ff <= 1'b0;
      end else if (out_load && reload) begin
         ref_loaded_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && reload) begin
         ref_pitch_ff   <= in_pitch_ff;
         ref_roll_ff    <= in_roll_ff;
         ref_yaw_ff     <= in_yaw_ff;
         still_since_ff <= in_stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_verdict_ff <= verdict;
      end
   end

`ifndef SYNTH
   a_ref_loaded_sticky: assert property (@(posedge clock) disable iff (reset)
      ref_loaded_ff |=> ref_loaded_ff)
      else $error("reference loaded flag dropped without reset");

   a_reload_captures_stamp: assert property (@(posedge clock) disable iff (reset)
      (out_load && reload) |=> (still_since_ff == $past(in_stamp_ff)))
      else $error("reload did not capture the sample stamp");

   a_empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ch.ready)
      else $error("input stage empty but not ready");

   a_settling_needs_ref: assert property (@(posedge clock) disable iff (reset)
      (out_load && !reload) |-> ref_loaded_ff)
      else $error("hold verdict without a loaded reference");
`endif

endmodule

// ===== tb/sv/stillness_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// stillness_tb_pkg
// Verdict predictor and result checker for the address stillness detector.
// Tracks the window, drift and hold registers alongside the block, keeps its own
// reference pose and start time, and queues one verdict per accepted sample.
// ---------------------------------------------------------------------------
package stillness_tb_pkg;

   import asd_pkg::*;

   class stillness_checker;
      cfg_type            settings;
      logic signed [15:0] anchor_pitch;
      logic signed [15:0] anchor_roll;
      logic signed [15:0] anchor_yaw;
      logic [31:0]        still_since;
      bit                 anchor_held;
      verdict_type        verdicts_due[$];
      int unsigned        mismatches;

      function new();
         settings.pitch_high   = RST_PITCH_HIGH;
         settings.pitch_low    = RST_PITCH_LOW;
         settings.roll_high    = RST_ROLL_HIGH;
         settings.roll_low     = RST_ROLL_LOW;
         settings.motion_limit = RST_MOTION_LIM;
         settings.hold_time_ms = RST_HOLD_TIME;
         anchor_pitch = '0;
         anchor_roll  = '0;
         anchor_yaw   = '0;
         still_since  = '0;
         anchor_held  = 1'b0;
         mismatches   = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                   logic [CSR_DATA_WIDTH-1:0] value);
         case (index)
            CSR_PITCH_HIGH: settings.pitch_high   = value;
            CSR_PITCH_LOW:  settings.pitch_low    = value;
            CSR_ROLL_HIGH:  settings.roll_high    = value;
            CSR_ROLL_LOW:   settings.roll_low     = value;
            CSR_MOTION_LIM: settings.motion_limit = value;
            CSR_HOLD_TIME:  settings.hold_time_ms = value;
            default: ;
         endcase
      endfunction

      // exact difference, no wrap at 16 bits
      function bit drifted(logic signed [15:0] cur, logic signed [15:0] anchor);
         int gap;
         gap = int'(cur) - int'(anchor);
         if (gap < 0) gap = -gap;
         return gap > int'(settings.motion_limit);
      endfunction

      function void note_sample(logic signed [15:0] pitch, logic signed [15:0] roll,
                                logic signed [15:0] yaw, logic [31:0] stamp);
         verdict_type verdict;
         logic [31:0] elapsed;
         if (int'(pitch) > int'(settings.pitch_high) || int'(pitch) < int'(settings.pitch_low) ||
             int'(roll) > int'(settings.roll_high) || int'(roll) < int'(settings.roll_low)) begin
            verdict = VERDICT_OUTSIDE;
         end else if (!anchor_held || drifted(pitch, anchor_pitch) ||
                      drifted(roll, anchor_roll) || drifted(yaw, anchor_yaw)) begin
            verdict = VERDICT_MOVED;
         end else begin
            elapsed = stamp - still_since;
            verdict = (elapsed >= 32'(settings.hold_time_ms)) ? VERDICT_AT_ADDRESS
                                                               : VERDICT_SETTLING;
         end
         // an outside sample reloads the reference too
         if (verdict == VERDICT_OUTSIDE || verdict == VERDICT_MOVED) begin
            anchor_pitch = pitch;
            anchor_roll  = roll;
            anchor_yaw   = yaw;
            still_since  = stamp;
            anchor_held  = 1'b1;
         end
         verdicts_due.push_back(verdict);
      endfunction

      function void check_result(logic at_address, logic [1:0] verdict);
         verdict_type want;
         logic        want_at;
         if (verdicts_due.size() == 0) begin
            $error("verdict: expected none, got %0d", verdict);
            mismatches++;
            return;
         end
         want    = verdicts_due.pop_front();
         want_at = (want == VERDICT_AT_ADDRESS);
         if (verdict !== want) begin
            $error("verdict: expected %0d, got %0d", want, verdict);
            mismatches++;
         end
         if (at_address !== want_at) begin
            $error("at_address: expected %0b, got %0b", want_at, at_address);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and checking for address_stillness_detector_core.
// Directed samples walk the window edges, drift limits and stamp wrap under
// the reset settings, then register phases cover empty windows, zero and
// full limits and random settings, each with random still runs, broken runs
// and raw noise under varying sender idle and receiver stall.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import asd_pkg::*;
   import stillness_tb_pkg::*;

   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 8;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   int                         src_idle_pct;
   int                         snk_stall_pct;
   int unsigned                cycle_count = 0;
   stillness_checker           board = new();

   asd_req_if #(.ANGLE_WIDTH(16), .STAMP_WIDTH(32)) req_ch ();
   asd_rsp_if rsp_ch ();

   address_stillness_detector_core #(
      .ANGLE_WIDTH(16),
      .STAMP_WIDTH(32)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: check on handshake, then pick next ready
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.at_address, rsp_ch.verdict);
         rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   task automatic send_sample(input int pitch, input int roll, input int yaw,
                              input logic [31:0] stamp);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.pitch_angle <= 16'(pitch);
      req_ch.roll_angle  <= 16'(roll);
      req_ch.yaw_angle   <= 16'(yaw);
      req_ch.stamp_ms    <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_sample(16'(pitch), 16'(roll), 16'(yaw), stamp);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (board.verdicts_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_register(index, value);
   endtask

   task automatic load_settings(input cfg_type c, input bit poke_spare);
      write_reg(CSR_PITCH_HIGH, c.pitch_high);
      write_reg(CSR_PITCH_LOW, c.pitch_low);
      write_reg(CSR_ROLL_HIGH, c.roll_high);
      write_reg(CSR_ROLL_LOW, c.roll_low);
      write_reg(CSR_MOTION_LIM, c.motion_limit);
      write_reg(CSR_HOLD_TIME, c.hold_time_ms);
      if (poke_spare) begin
         write_reg(CSR_SPARE_LO, 16'hFFFF);
         write_reg(CSR_SPARE_HI, 16'h5A5A);
      end
      csr_we <= 1'b0;
   endtask

   function automatic cfg_type random_settings();
      cfg_type c;
      int      a, b;
      a = int'($urandom_range(46080)) - 23040;
      b = int'($urandom_range(46080)) - 23040;
      c.pitch_high = 16'((a > b) ? a : b);
      c.pitch_low  = 16'((a > b) ? b : a);
      a = int'($urandom_range(46080)) - 23040;
      b = int'($urandom_range(46080)) - 23040;
      c.roll_high    = 16'((a > b) ? a : b);
      c.roll_low     = 16'((a > b) ? b : a);
      c.motion_limit = 16'($urandom_range(46080));
      c.hold_time_ms = 16'($urandom_range(3000));
      return c;
   endfunction

   function automatic int pick_in(int lo, int hi);
      if (lo > hi) return int'($urandom_range(46080)) - 23040;
      case ($urandom_range(7))
         0: return lo;
         1: return hi;
         default: return lo + int'($urandom_range(hi - lo));
      endcase
   endfunction

   function automatic int jitter(int lim);
      if (lim == 0) return 0;
      case ($urandom_range(9))
         0: return lim;
         1: return -lim;
         default: return int'($urandom_range(2 * lim)) - lim;
      endcase
   endfunction

   task automatic run_directed();
      send_sample(0, 0, 0, 32'd0);
      send_sample(640, -640, 640, 32'd999);
      send_sample(0, 0, 0, 32'd1000);
      send_sample(0, 0, 641, 32'd1001);
      send_sample(23040, 0, 641, 32'd1002);
      send_sample(23040, 23040, 641, 32'd1500);
      send_sample(23040, 23040, 641, 32'd2502);
      send_sample(23041, 0, 0, 32'd2503);
      // reference taken from the outside sample above
      send_sample(23000, 0, 0, 32'd2600);
      send_sample(-23041, 0, 0, 32'd2601);
      send_sample(0, 23041, 0, 32'd2602);
      send_sample(0, -23041, 0, 32'd2603);
      send_sample(-32768, 32767, -32768, 32'hFFFF_FFFF);
      send_sample(-23040, -23040, -32768, 32'hFFFF_FF00);
      send_sample(-23040, -23040, -32768, 32'hFFFF_FFF0);
      // stamp wraps through zero
      send_sample(-23040, -23040, -32768, 32'h0000_02E7);
      send_sample(-23040, -23040, -32768, 32'h0000_02E8);
      send_sample(32767, -32768, 32767, 32'h7FFF_FFFF);
      send_sample(-22400, -22400, 32767, 32'h8000_0000);
      send_sample(-22400, -22400, 32127, 32'h8000_03E8);
   endtask

   task automatic run_random(input int count);
      int          sent, kind, lim, full_lim, span, len, break_at, k;
      int          bp, br, by;
      logic [31:0] stamp;
      sent = 0;
      while (sent < count) begin
         kind     = $urandom_range(99);
         full_lim = int'(board.settings.motion_limit);
         lim      = (full_lim > 4000) ? 4000 : full_lim;
         span     = int'(board.settings.hold_time_ms) / 3 + 2;
         if (kind < 15) begin
            send_sample($urandom, $urandom, $urandom, $urandom);
            sent++;
         end else begin
            bp = pick_in(int'(board.settings.pitch_low), int'(board.settings.pitch_high));
            br = pick_in(int'(board.settings.roll_low), int'(board.settings.roll_high));
            by = ($urandom_range(9) == 0) ? -32768 : int'($urandom_range(46080)) - 23040;
            stamp = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF - $urandom_range(span * 3)
                                             : $urandom;
            len      = $urandom_range(12, 3);
            break_at = (kind < 30) ? int'($urandom_range(len - 1, 1)) : -1;
            for (k = 0; k < len && sent < count; k++) begin
               if (k > 0) stamp += $urandom_range(span);
               if (k == break_at && $urandom_range(1)) begin
                  // one step past the pitch window
                  send_sample(int'(board.settings.pitch_high) + 1, br, by, stamp);
               end else if (k == break_at) begin
                  send_sample(bp, br,
                              by + full_lim + 1 + ($urandom_range(1) ? 0
                                                   : int'($urandom_range(3000))),
                              stamp);
               end else if (k == 0) begin
                  send_sample(bp, br, by, stamp);
               end else begin
                  send_sample(bp + jitter(lim), br + jitter(lim), by + jitter(lim), stamp);
               end
               sent++;
            end
         end
      end
   endtask

   initial begin
      cfg_type plan;
      int      phase, items;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_PITCH_HIGH;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.pitch_angle <= '0;
      req_ch.roll_angle  <= '0;
      req_ch.yaw_angle   <= '0;
      req_ch.stamp_ms    <= '0;
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (phase = 0; phase < 8; phase++) begin
         items = 220;
         case (phase)
            0: ;
            1, 7: plan = random_settings();
            2: plan = '{pitch_high: 16'sh7FFF, pitch_low: 16'sh8000, roll_high: 16'sh7FFF,
                        roll_low: 16'sh8000, motion_limit: 16'd0, hold_time_ms: 16'd0};
            3: plan = '{pitch_high: 16'sd23040, pitch_low: -16'sd23040,
                        roll_high: 16'sd23040, roll_low: -16'sd23040,
                        motion_limit: 16'd46080, hold_time_ms: 16'hFFFF};
            // empty pitch window, then empty roll window
            4: plan = '{pitch_high: -16'sd100, pitch_low: 16'sd100,
                        roll_high: 16'sd23040, roll_low: -16'sd23040,
                        motion_limit: 16'd640, hold_time_ms: 16'd1000};
            5: plan = '{pitch_high: 16'sd23040, pitch_low: -16'sd23040,
                        roll_high: -16'sd1, roll_low: 16'sd0,
                        motion_limit: 16'd640, hold_time_ms: 16'd1000};
            default: plan = '{pitch_high: 16'sd200, pitch_low: -16'sd200,
                              roll_high: 16'sd300, roll_low: -16'sd300,
                              motion_limit: 16'hFFFF, hold_time_ms: 16'd1};
         endcase
         if (phase == 4 || phase == 5) items = 40;
         if (phase != 0) begin
            wait_drained();
            load_settings(plan, phase == 1);
         end
         case (phase % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
            default: begin src_idle_pct = 16; snk_stall_pct = 16; end
         endcase
         run_random(items);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.verdicts_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
